// ===== sv/smx_pkg.sv =====
package smx_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int PROGRAM_MAX = 1024;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 11;
    localparam int LEN_RESET = 1024;
    // A length register value above this acts as this value.
    localparam int LEN_CLAMP = (PROGRAM_MAX < 2**LEN_W) ? PROGRAM_MAX : 2**LEN_W - 1;

    localparam int IN_TDATA_W  = DATA_W;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = ((DATA_W + DEPTH_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_ADD  = 2'd2,
        CMD_SUB  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_END   = 2'd3
    } status_t;

    // Register index of the length register.
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    typedef struct packed {
        logic latch;
        logic exec;
        logic fill;
        logic load;
    } smx_ctrl_t;

    typedef struct packed {
        logic need_fill;
        logic slot_free;
    } smx_stat_t;

endpackage

// ===== sv/smx_ctrl.sv =====
module smx_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  smx_pkg::smx_stat_t stat,
    output smx_pkg::smx_ctrl_t ctrl
);
    import smx_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FILL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.latch = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = stat.need_fill ? S_FILL : S_DONE;
            end
            S_FILL:
            begin
                ctrl.fill  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.slot_free)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

`ifndef NO_ASSERTIONS
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(state_reg == S_IDLE && in_valid))
        else $error("execute step without an accepted item");

    a_fill_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |=> state_reg == S_DONE)
        else $error("refill step not followed by result step");
`endif

endmodule

// ===== sv/smx_datapath.sv =====
module smx_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  smx_pkg::smx_ctrl_t                    ctrl,
    output smx_pkg::smx_stat_t                    stat,
    input  logic [smx_pkg::IN_TUSER_W-1:0]        in_command,
    input  logic signed [smx_pkg::DATA_W-1:0]     in_operand,
    input  logic [smx_pkg::LEN_W-1:0]             program_length,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            out_status,
    output logic signed [smx_pkg::DATA_W-1:0]     out_top_value,
    output logic [smx_pkg::DEPTH_W-1:0]           out_stack_depth,
    output logic                                  out_program_done
);
    import smx_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] val_reg;

    // top_reg is the entry at depth-1, second_reg the entry at depth-2.
    logic [DATA_W-1:0]  top_reg, top_next;
    logic [DATA_W-1:0]  second_reg, second_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    status_t            status_reg, status_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic [DATA_W-1:0]  out_top_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    logic               out_done_reg;

    logic [LEN_W-1:0]   eff_len;
    logic               running;
    logic [DEPTH_W-1:0] depth_m2;
    logic [DEPTH_W-1:0] depth_m3;
    logic [DATA_W-1:0]  alu_result;

    assign eff_len  = (program_length > LEN_W'(LEN_CLAMP)) ? LEN_W'(LEN_CLAMP)
                                                           : program_length;
    assign running  = (count_reg < eff_len);
    assign depth_m2 = depth_reg - DEPTH_W'(2);
    assign depth_m3 = depth_reg - DEPTH_W'(3);
    assign mem_raddr = depth_m3[ADDR_W-1:0];
    assign alu_result = (cmd_reg == CMD_ADD) ? (top_reg + second_reg)
                                             : (top_reg - second_reg);

    // After a pop, add or subtract on three or more entries the new second
    // entry must come back from memory.
    assign stat.need_fill = running && (cmd_reg != CMD_PUSH)
                            && (depth_reg >= DEPTH_W'(3));
    assign stat.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        top_next    = top_reg;
        second_next = second_reg;
        depth_next  = depth_reg;
        count_next  = count_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = depth_reg[ADDR_W-1:0];
        mem_wdata   = val_reg;
        if (ctrl.exec)
        begin
            if (!running)
            begin
                status_next = ST_END;
            end
            else
            begin
                count_next  = count_reg + LEN_W'(1);
                status_next = ST_OK;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (depth_reg >= DEPTH_W'(STACK_DEPTH))
                        begin
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            top_next    = val_reg;
                            second_next = top_reg;
                            depth_next  = depth_reg + DEPTH_W'(1);
                        end
                    end
                    CMD_POP:
                    begin
                        if (depth_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            top_next   = second_reg;
                            depth_next = depth_reg - DEPTH_W'(1);
                        end
                    end
                    default:
                    begin
                        if (depth_reg < DEPTH_W'(2))
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = depth_m2[ADDR_W-1:0];
                            mem_wdata  = alu_result;
                            top_next   = alu_result;
                            depth_next = depth_reg - DEPTH_W'(1);
                        end
                    end
                endcase
            end
        end
        if (ctrl.fill)
        begin
            second_next = rdata_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        second_reg <= second_next;
        status_reg <= status_next;
        if (ctrl.latch)
        begin
            cmd_reg <= cmd_t'(in_command);
            val_reg <= in_operand;
        end
        if (ctrl.load)
        begin
            out_status_reg <= status_reg;
            out_top_reg    <= (depth_reg != '0) ? top_reg : '0;
            out_depth_reg  <= depth_reg;
            out_done_reg   <= !running;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_top_value    = out_top_reg;
    assign out_stack_depth  = out_depth_reg;
    assign out_program_done = out_done_reg;

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_count_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg != $past(count_reg)) |-> $past(ctrl.exec))
        else $error("instruction count moved outside an execute step");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");
`endif

endmodule

// ===== sv/stack_machine_executor.sv =====
// Stack machine executor: each input item carries one instruction (push,
// pop, add or subtract) for a 16-entry stack of 32-bit words, and yields one
// result item with status, new top, depth and a program-done flag. The result
// is registered after an execute step for a push, or for any instruction that
// fails or comes after the program end. A pop, add or subtract that leaves two
// or more entries adds a refill step before the result, because the new second
// entry is refetched through the stack memory's registered read port. The
// next item is accepted only after the result is registered, while that
// result may still wait to be taken. The program length register lives at
// byte address 0; values above 1024 act as 1024, and the instruction counter
// is cleared only by reset.
module stack_machine_executor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // operand_value[31:0]
    input  logic [smx_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // command[1:0]
    input  logic [smx_pkg::IN_TUSER_W-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // top_value[31:0], stack_depth[36:32], zero fill
    output logic [smx_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // status[1:0], program_done[2]
    output logic [smx_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [smx_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [smx_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [smx_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import smx_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             reg_sel;

    smx_ctrl_t ctrl;
    smx_stat_t stat;

    logic [1:0]         status;
    logic [DATA_W-1:0]  top_value;
    logic [DEPTH_W-1:0] stack_depth;
    logic               program_done;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1] == REG_PROGRAM_LENGTH);

    always_comb
    begin
        len_next = len_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(LEN_RESET);
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(len_reg) : '0;

    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    smx_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .in_command       (s_axis_tuser),
        .in_operand       (s_axis_tdata[DATA_W-1:0]),
        .program_length   (len_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_status       (status),
        .out_top_value    (top_value),
        .out_stack_depth  (stack_depth),
        .out_program_done (program_done)
    );

    assign m_axis_tdata = OUT_TDATA_W'({stack_depth, top_value});
    assign m_axis_tuser = {program_done, status};

endmodule
